FILE: src/cfa_pkg.sv
package cfa_pkg;

  // default table depth
  localparam int FRAMES_DEF = 1024;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 1;

  // configuration reset values
  localparam logic [CFG_W-1:0] ACTIVE_RST   = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RESERVED_RST = '0;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_ACTIVE   = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_RESERVED = 1'b1;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  page_count;
    logic [IDX_W-1:0]  free_frame;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  frame_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              sweep;
    logic              sweep_mark;
    logic              scan;
    logic              mark;
    logic              free_rd;
    logic              free_chk;
    logic              free_clr;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
    logic              res_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sweep_last;
    logic              alloc_bad;
    logic              scan_found;
    logic              scan_end;
    logic              mark_last;
    logic              free_range_bad;
    logic              size_zero;
    logic              clr_done;
  } stat_t;

endpackage

FILE: src/contiguous_frame_allocator_unit.sv
// one request at a time; in_ready is low from acceptance until the result is queued
// alloc: first-fit scan to the fit, then its pages marked; no fit: scan of all active frames
// free: walk bounded by block size and active frames; init: sweep over all FRAMES frames
// bad alloc, out of range free, unused mode: no walk; zero-size free: stops after size read
// reset: synchronous active low, then a clearing pass over all FRAMES frames of the frame
// table during which no request is taken; configuration writes are taken at any time
module contiguous_frame_allocator_unit #(
  parameter int FRAMES = cfa_pkg::FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cfa_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cfa_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [cfa_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [cfa_pkg::CFG_W-1:0]   cfg_data
);
  import cfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // frame table and walk
  cfa_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

FILE: src/cfa_datapath.sv
module cfa_datapath #(
  parameter int FRAMES = cfa_pkg::FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfa_pkg::cmd_t               cmd,
  output cfa_pkg::stat_t              stat,
  input  cfa_pkg::in_item_t           in_data,
  input  logic                        cfg_we,
  input  logic [cfa_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [cfa_pkg::CFG_W-1:0]   cfg_data,
  output cfa_pkg::out_item_t          out_data
);
  import cfa_pkg::*;

  localparam int FW  = $clog2(FRAMES);
  localparam int CW  = ($clog2(FRAMES + 1) > CNT_W) ? $clog2(FRAMES + 1) : CNT_W;
  localparam logic [CW-1:0] FRAMES_C = CW'(FRAMES);
  localparam logic [CW-1:0] LAST_C   = CW'(FRAMES - 1);

  // frame table
  logic             used_mem [FRAMES];
  logic [CNT_W-1:0] size_mem [FRAMES];

  logic [CFG_W-1:0]  active_r, reserved_r;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  first_r;
  logic [CW-1:0]     act_r, res_r;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [FW-1:0]     start_r, start_nxt;
  logic [FW-1:0]     chk_addr_r;
  logic              rd_vld_r, rd_vld_nxt;
  logic              used_q;
  logic [CNT_W-1:0]  size_q;
  out_item_t         out_r;

  logic              used_we, used_wd, used_re;
  logic [FW-1:0]     used_wa, used_ra;
  logic              size_we, size_re;
  logic [FW-1:0]     size_wa, size_ra;
  logic [CNT_W-1:0]  size_wd;

  logic [CW-1:0]     act_calc, res_calc, run_inc;
  logic [FW-1:0]     ptr_a, first_a, start_calc;
  logic              issue, hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= ACTIVE_RST;
      reserved_r <= RESERVED_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ACTIVE:   active_r   <= cfg_data;
        CFG_RESERVED: reserved_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // managed and reserved frame counts
  always_comb begin
    act_calc = (CW'(active_r) > FRAMES_C) ? FRAMES_C : CW'(active_r);
    res_calc = (CW'(reserved_r) > act_calc) ? act_calc : CW'(reserved_r);
  end

  assign ptr_a      = ptr_r[FW-1:0];
  assign first_a    = FW'(first_r);
  assign run_inc    = run_r + CW'(1);
  assign hit        = rd_vld_r && !used_q && (run_inc == CW'(count_r));
  assign start_calc = chk_addr_r + FW'(1) - FW'(count_r);
  assign issue      = ptr_r < act_r;

  // status towards the controller
  always_comb begin
    stat.mode           = mode_r;
    stat.sweep_last     = ptr_r == LAST_C;
    stat.alloc_bad      = (count_r == '0) || (CW'(count_r) > act_r);
    stat.scan_found     = cmd.scan && hit;
    stat.scan_end       = !rd_vld_r && !issue;
    stat.mark_last      = rem_r == CW'(1);
    stat.free_range_bad = CW'(first_r) >= act_r;
    stat.size_zero      = size_q == '0;
    stat.clr_done       = (rem_r == '0) || (ptr_r >= act_r);
  end

  // table access and walk counters
  always_comb begin
    used_we    = 1'b0;
    used_wa    = ptr_a;
    used_wd    = 1'b0;
    used_re    = 1'b0;
    used_ra    = ptr_a;
    size_we    = 1'b0;
    size_wa    = ptr_a;
    size_wd    = '0;
    size_re    = 1'b0;
    size_ra    = first_a;
    ptr_nxt    = ptr_r;
    run_nxt    = run_r;
    rem_nxt    = rem_r;
    start_nxt  = start_r;
    rd_vld_nxt = 1'b0;

    if (cmd.load) begin
      ptr_nxt = '0;
      run_nxt = '0;
    end

    // clearing or init sweep, one frame a cycle
    if (cmd.sweep) begin
      used_we = 1'b1;
      used_wd = cmd.sweep_mark && (ptr_r < res_r);
      size_we = 1'b1;
      size_wd = CNT_W'(used_wd);
      ptr_nxt = ptr_r + CW'(1);
    end

    // first-fit scan, read issued in the cycle before its check
    if (cmd.scan) begin
      if (rd_vld_r) begin
        run_nxt = used_q ? '0 : run_inc;
      end
      if (hit) begin
        start_nxt = start_calc;
        size_we   = 1'b1;
        size_wa   = start_calc;
        size_wd   = count_r;
        ptr_nxt   = CW'(start_calc);
        rem_nxt   = CW'(count_r);
      end else if (issue) begin
        used_re    = 1'b1;
        ptr_nxt    = ptr_r + CW'(1);
        rd_vld_nxt = 1'b1;
      end
    end

    // mark the found run as used
    if (cmd.mark) begin
      used_we = 1'b1;
      used_wd = 1'b1;
      ptr_nxt = ptr_r + CW'(1);
      rem_nxt = rem_r - CW'(1);
    end

    if (cmd.free_rd) begin
      size_re = 1'b1;
    end

    // drop the block size and set up the release walk
    if (cmd.free_chk && (size_q != '0)) begin
      size_we = 1'b1;
      size_wa = first_a;
      size_wd = '0;
      rem_nxt = CW'(size_q);
      ptr_nxt = CW'(first_r);
    end

    if (cmd.free_clr && !stat.clr_done) begin
      used_we = 1'b1;
      used_wd = 1'b0;
      ptr_nxt = ptr_r + CW'(1);
      rem_nxt = rem_r - CW'(1);
    end
  end

  // used bit store
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (used_re) begin
      used_q <= used_mem[used_ra];
    end
  end

  // block size store
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (size_re) begin
      size_q <= size_mem[size_ra];
    end
  end

  // walk pointer and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    run_r   <= run_nxt;
    rem_r   <= rem_nxt;
    start_r <= start_nxt;
    if (used_re) begin
      chk_addr_r <= ptr_a;
    end
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      count_r <= in_data.page_count;
      first_r <= in_data.free_frame;
      act_r   <= act_calc;
      res_r   <= res_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.status      <= cmd.res_status;
      out_r.frame_index <= cmd.res_idx ? IDX_W'(start_r) : '0;
    end
  end

  assign out_data = out_r;

endmodule

FILE: src/cfa_ctrl.sv
module cfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cfa_pkg::stat_t stat,
  output cfa_pkg::cmd_t  cmd
);
  import cfa_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_DISPATCH = 10'b00_0000_0100,
    S_SWEEP    = 10'b00_0000_1000,
    S_SCAN     = 10'b00_0001_0000,
    S_MARK     = 10'b00_0010_0000,
    S_FREE_RD  = 10'b00_0100_0000,
    S_FREE_CHK = 10'b00_1000_0000,
    S_FREE_CLR = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STAT_W-1:0] code_r, code_nxt;
  logic              idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    idx_nxt        = idx_r;
    cmd            = '0;
    cmd.res_status = code_r;
    cmd.res_idx    = idx_r;

    case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        code_nxt  = ST_OK;
        idx_nxt   = 1'b0;
        state_nxt = S_DONE;
        case (stat.mode)
          MODE_ALLOC: begin
            if (stat.alloc_bad) begin
              code_nxt = ST_NOFIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          MODE_FREE: begin
            if (stat.free_range_bad) begin
              code_nxt = ST_BADFREE;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end
          MODE_INIT: begin
            state_nxt = S_SWEEP;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_mark = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_found) begin
          state_nxt = S_MARK;
        end else if (stat.scan_end) begin
          code_nxt  = ST_NOFIT;
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.mark_last) begin
          idx_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        if (stat.size_zero) begin
          code_nxt  = ST_BADFREE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_CLR;
        end
      end
      S_FREE_CLR: begin
        cmd.free_clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // result beat pending flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      code_r      <= ST_OK;
      idx_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

FILE: src/cfa_checker.sv
module cfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input cfa_pkg::out_item_t          out_data
);
  import cfa_pkg::*;

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // only a successful beat carries a frame index
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.frame_index == '0)
    else $error("failed request reports a frame index");

  // status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_NOFIT) ||
                  (out_data.status == ST_BADFREE))
    else $error("undefined status code");

  // an accepted request leaves the unit busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  // clearing pass after reset: nothing taken, nothing shown
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("unit active straight after reset");

endmodule

bind contiguous_frame_allocator_unit cfa_checker u_cfa_checker (.*);

FILE: bench/contiguous_frame_allocator_unit_tb.sv
`timescale 1ns / 100ps

module contiguous_frame_allocator_unit_tb;
  import cfa_pkg::*;

  localparam int TABLE_N = FRAMES_DEF;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2100;
  localparam int SEG_N = 10;
  localparam int RAND_TOTAL = 555;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    in_item_t          beat;
    out_item_t         want;
    logic [CFG_IW-1:0] reg_idx;
    logic [CFG_W-1:0]  reg_val;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // shadow frame table and registers
  logic             frame_used [TABLE_N];
  logic [CNT_W-1:0] frame_size [TABLE_N];
  logic [CFG_W-1:0] m_active = ACTIVE_RST;
  logic [CFG_W-1:0] m_reserved = RESERVED_RST;

  out_item_t pending_replies [$];
  out_item_t last_reply;
  int        live_frames [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        tx_idle_pct = 10;
  int        rx_idle_pct = 54;
  int        hold_reqs = 0;
  int        holds_done = 0;

  int seg_act [SEG_N] = '{16, 64, 1, 37, 1024, 8, 128, 2047, 0, 96};
  int seg_res [SEG_N] = '{0, 4, 0, 5, 0, 2, 130, 3, 2, 1};
  int seg_len [SEG_N] = '{70, 80, 25, 70, 40, 60, 60, 30, 15, 105};

  contiguous_frame_allocator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t mk_beat(input logic [MODE_W-1:0] m, input int cnt, input int frm);
    in_item_t b;
    b.mode       = m;
    b.page_count = CNT_W'(cnt);
    b.free_frame = IDX_W'(frm);
    return b;
  endfunction

  function automatic plan_row_t r_chk(input logic [MODE_W-1:0] m, input int cnt, input int frm);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.beat = mk_beat(m, cnt, frm);
    return r;
  endfunction

  function automatic plan_row_t r_fix(input logic [MODE_W-1:0] m, input int cnt, input int frm,
                                      input logic [STAT_W-1:0] st, input int idx);
    plan_row_t r;
    r = '0;
    r.kind = ROW_FIXED;
    r.beat = mk_beat(m, cnt, frm);
    r.want.status = st;
    r.want.frame_index = IDX_W'(idx);
    return r;
  endfunction

  function automatic plan_row_t r_reg(input logic [CFG_IW-1:0] idx, input int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  function automatic int managed_frames();
    return (int'(m_active) > TABLE_N) ? TABLE_N : int'(m_active);
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_N; i++) begin
      frame_used[i] = 1'b0;
      frame_size[i] = '0;
    end
  endfunction

  // first-fit allocate, block free and table init on the shadow table
  function automatic out_item_t predict_frame_op(input in_item_t beat);
    out_item_t r;
    int act, cnt, ff, run, start, sz, lim;
    bit found;
    r.status = ST_OK;
    r.frame_index = '0;
    act = managed_frames();
    cnt = int'(beat.page_count);
    ff = int'(beat.free_frame);
    run = 0;
    start = 0;
    found = 1'b0;
    case (beat.mode)
      MODE_ALLOC: begin
        if (cnt != 0 && cnt <= act) begin
          for (int i = 0; i < act && !found; i++) begin
            if (frame_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                start = i + 1 - cnt;
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          frame_size[start] = CNT_W'(cnt);
          for (int i = 0; i < cnt; i++) frame_used[start + i] = 1'b1;
          r.frame_index = IDX_W'(start);
        end else begin
          r.status = ST_NOFIT;
        end
      end
      MODE_FREE: begin
        if (ff >= act || frame_size[ff] == 0) begin
          r.status = ST_BADFREE;
        end else begin
          sz = int'(frame_size[ff]);
          frame_size[ff] = '0;
          // bits beyond the managed frames stay as they are
          for (int i = 0; i < sz && ff + i < act; i++) frame_used[ff + i] = 1'b0;
        end
      end
      MODE_INIT: begin
        lim = (int'(m_reserved) > act) ? act : int'(m_reserved);
        wipe_table();
        for (int i = 0; i < lim; i++) begin
          frame_used[i] = 1'b1;
          frame_size[i] = CNT_W'(1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one beat, predict on acceptance; returns at a falling edge with valid still up
  task automatic put_beat(input in_item_t beat, input bit fixed, input out_item_t want);
    out_item_t guess;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    guess = predict_frame_op(beat);
    last_reply = guess;
    pending_replies.push_back(fixed ? want : guess);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding reply
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(val);
    if (idx == CFG_ACTIVE) m_active = CFG_W'(val);
    else m_reserved = CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // reply checker
  always @(posedge clk) begin : reply_chk
    out_item_t want;
    if (out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: status %0d index %0d", out_data.status,
                   out_data.frame_index);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.status !== want.status || out_data.frame_index !== want.frame_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: status exp %0d got %0d, index exp %0d got %0d",
                     want.status, out_data.status, want.frame_index, out_data.frame_index);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int sent, roll, cap, k, frm;
    sent = 0;
    wipe_table();
    plan = '{
      r_fix(MODE_ALLOC, 0, 0, ST_NOFIT, 0),         // zero page count
      r_fix(MODE_ALLOC, 2047, 0, ST_NOFIT, 0),      // request beyond the active frames
      r_fix(MODE_ALLOC, 1, 0, ST_OK, 0),
      r_chk(MODE_ALLOC, 1024, 0),
      r_fix(MODE_FREE, 0, 0, ST_OK, 0),
      r_fix(MODE_ALLOC, 1024, 0, ST_OK, 0),         // whole table in one block
      r_fix(MODE_FREE, 0, 1023, ST_BADFREE, 0),     // not a block start
      r_fix(MODE_SPARE, 2047, 1023, ST_OK, 0),      // unused mode
      r_fix(MODE_FREE, 0, 0, ST_OK, 0),
      r_chk(MODE_ALLOC, 3, 0),
      r_chk(MODE_ALLOC, 2, 0),
      r_chk(MODE_FREE, 0, 0),
      r_chk(MODE_ALLOC, 2, 0),                      // first fit into the hole
      r_reg(CFG_RESERVED, 1024),
      r_chk(MODE_INIT, 0, 0),
      r_fix(MODE_ALLOC, 1, 0, ST_NOFIT, 0),         // table full
      r_chk(MODE_FREE, 0, 1023),
      r_reg(CFG_ACTIVE, 0),
      r_fix(MODE_ALLOC, 1, 0, ST_NOFIT, 0),         // no active frames
      r_fix(MODE_FREE, 0, 0, ST_BADFREE, 0),
      r_reg(CFG_ACTIVE, 2047),
      r_reg(CFG_RESERVED, 2047),
      r_chk(MODE_INIT, 0, 0),                       // both counts above the table
      r_reg(CFG_ACTIVE, 16),
      r_reg(CFG_RESERVED, 20),
      r_chk(MODE_INIT, 0, 0),                       // reserved above active
      r_fix(MODE_FREE, 0, 1023, ST_BADFREE, 0),     // out of range
      r_chk(MODE_FREE, 0, 15),
      r_reg(CFG_ACTIVE, 1024),
      r_reg(CFG_RESERVED, 0),
      r_chk(MODE_INIT, 0, 0),
      r_fix(MODE_ALLOC, 10, 0, ST_OK, 0),
      r_reg(CFG_ACTIVE, 4),
      r_chk(MODE_FREE, 0, 0),                       // block reaching past the active frames
      r_reg(CFG_ACTIVE, 1024),
      r_chk(MODE_ALLOC, 5, 0)
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, int'(plan[i].reg_val));
      end else begin
        put_beat(plan[i].beat, plan[i].kind == ROW_FIXED, plan[i].want);
      end
    end

    // random segments, one register setting each
    for (int s = 0; s < SEG_N; s++) begin
      settle();
      write_reg(CFG_ACTIVE, seg_act[s]);
      write_reg(CFG_RESERVED, seg_res[s]);
      live_frames.delete();
      put_beat(mk_beat(MODE_INIT, 0, 0), 1'b0, '0);
      for (int n = 0; n < seg_len[s]; n++) begin
        case (sent * 3 / RAND_TOTAL)
          0: begin tx_idle_pct = 10; rx_idle_pct = 54; end
          1: begin tx_idle_pct = 54; rx_idle_pct = 10; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        if (s == 1 && n == 10) hold_reqs++;
        if (s == 3 && n == 30) settle();
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          cap = managed_frames() / 4;
          if (cap < 1) cap = 1;
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, cap);
          put_beat(mk_beat(MODE_ALLOC, k, $urandom_range(0, 1023)), 1'b0, '0);
          if (last_reply.status == ST_OK) live_frames.push_back(int'(last_reply.frame_index));
        end else if (roll < 85 && live_frames.size() != 0) begin
          k = $urandom_range(0, live_frames.size() - 1);
          frm = live_frames[k];
          live_frames.delete(k);
          put_beat(mk_beat(MODE_FREE, $urandom_range(0, 2047), frm), 1'b0, '0);
        end else if (roll < 93) begin
          put_beat(mk_beat(MODE_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023)),
                   1'b0, '0);
        end else if (roll < 96) begin
          live_frames.delete();
          put_beat(mk_beat(MODE_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023)),
                   1'b0, '0);
        end else begin
          put_beat(mk_beat(MODE_SPARE, $urandom_range(0, 2047), $urandom_range(0, 1023)),
                   1'b0, '0);
        end
        sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cfa_pkg.sv
src/cfa_datapath.sv
src/cfa_ctrl.sv
src/contiguous_frame_allocator_unit.sv
src/cfa_checker.sv
bench/contiguous_frame_allocator_unit_tb.sv
